### sv/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants
// Beat formats, configuration register map and limits for the timestamp
// continuity checker.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned CYCLES_PER_SECOND = 16;
  localparam logic [15:0] LAST_SUBCYCLE     = 16'(CYCLES_PER_SECOND - 1);

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd2;

  localparam logic [15:0] RING_SLOTS_RST   = 16'd16;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd52;
  localparam logic [15:0] MAX_INTERVAL_RST = 16'd72;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] ring_slot;
    logic [31:0] gps_seconds;
    logic [15:0] gps_subcycle;
    logic [15:0] interval_ms;
    logic [7:0]  model_count;
  } in_t;

  typedef struct packed {
    logic        slot_jump;
    logic        slot_cycle_mismatch;
    logic        gps_jump;
    logic        bad_interval;
    logic        count_changed;
    logic        any_error;
    logic [15:0] slot_jump_total;
    logic [15:0] mismatch_total;
    logic [15:0] gps_jump_total;
  } out_t;

  typedef struct packed {
    logic [15:0] ring_slots;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
  } cfg_t;

endpackage

### sv/tcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcc_cfg_regs: configuration register file
// Holds ring size and interval window; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tcc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data,
  output tcc_pkg::cfg_t                  cfg
);

  tcc_pkg::cfg_t cfg_r;
  tcc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tcc_pkg::REG_RING_SLOTS:   cfg_nxt.ring_slots      = cfg_data;
        tcc_pkg::REG_MIN_INTERVAL: cfg_nxt.min_interval_ms = cfg_data;
        tcc_pkg::REG_MAX_INTERVAL: cfg_nxt.max_interval_ms = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_slots      <= tcc_pkg::RING_SLOTS_RST;
      cfg_r.min_interval_ms <= tcc_pkg::MIN_INTERVAL_RST;
      cfg_r.max_interval_ms <= tcc_pkg::MAX_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/tcc_input_stage.sv
// ----------------------------------------------------------------------------
// tcc_input_stage: input beat register
// Captures one sample beat and hands it to the check stage.
// ----------------------------------------------------------------------------
module tcc_input_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcc_pkg::in_t  in_data,
  output logic          s1_valid,
  output tcc_pkg::in_t  s1_data,
  input  logic          s1_take
);

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  tcc_pkg::in_t s1_data_r;
  logic         load;

  // hold while a beat sits here and the check stage cannot take it
  assign in_stall = s1_valid_r && !s1_take;
  assign load     = in_valid && !in_stall;

  assign s1_valid_nxt = load ? 1'b1 : (s1_take ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

### sv/tcc_check.sv
// ----------------------------------------------------------------------------
// tcc_check: continuity checks and result register
// Compares a sample against the stored one, updates counters, registers result.
// ----------------------------------------------------------------------------
module tcc_check (
  input  logic           clk,
  input  logic           rst_n,
  input  tcc_pkg::cfg_t  cfg,
  input  logic           s1_valid,
  input  tcc_pkg::in_t   s1_data,
  output logic           s1_take,
  output logic           out_valid,
  input  logic           out_stall,
  output tcc_pkg::out_t  out_data
);

  logic          primed_r;
  logic [15:0]   last_slot_r;
  logic [31:0]   last_seconds_r;
  logic [15:0]   last_subcycle_r;
  logic [7:0]    last_models_r;
  logic [15:0]   jump_cnt_r;
  logic [15:0]   mis_cnt_r;
  logic [15:0]   tjump_cnt_r;
  logic [15:0]   jump_cnt_nxt;
  logic [15:0]   mis_cnt_nxt;
  logic [15:0]   tjump_cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  tcc_pkg::out_t out_data_r;
  tcc_pkg::out_t res;

  logic [16:0]   expect_sum;
  logic [15:0]   expect_slot;
  logic [16:0]   sub_step;
  logic          same_sec_step;
  logic          next_sec_step;
  logic          f_jump;
  logic          f_mis;
  logic          f_time;
  logic          f_ivl;
  logic          f_cnt;

  assign s1_take = s1_valid && (!out_valid_r || !out_stall);

  assign expect_sum  = {1'b0, last_slot_r} + 17'd1;
  assign expect_slot = (expect_sum >= {1'b0, cfg.ring_slots}) ? 16'd0 : expect_sum[15:0];
  assign sub_step    = {1'b0, last_subcycle_r} + 17'd1;

  assign same_sec_step = (s1_data.gps_seconds == last_seconds_r) &&
                         ({1'b0, s1_data.gps_subcycle} == sub_step);
  assign next_sec_step = (s1_data.gps_seconds == last_seconds_r + 32'd1) &&
                         (s1_data.gps_subcycle == 16'd0) &&
                         (last_subcycle_r == tcc_pkg::LAST_SUBCYCLE);

  assign f_mis  = s1_data.ring_slot != s1_data.gps_subcycle;
  assign f_jump = primed_r && (s1_data.ring_slot != expect_slot);
  assign f_time = primed_r && !(same_sec_step || next_sec_step);
  assign f_ivl  = primed_r && ((s1_data.interval_ms < cfg.min_interval_ms) ||
                               (s1_data.interval_ms > cfg.max_interval_ms));
  assign f_cnt  = primed_r && (s1_data.model_count != last_models_r);

  // saturating counters
  assign jump_cnt_nxt  = (f_jump && jump_cnt_r != tcc_pkg::CNT_MAX) ? jump_cnt_r + 16'd1
                                                                   : jump_cnt_r;
  assign mis_cnt_nxt   = (f_mis && mis_cnt_r != tcc_pkg::CNT_MAX) ? mis_cnt_r + 16'd1
                                                                 : mis_cnt_r;
  assign tjump_cnt_nxt = (f_time && tjump_cnt_r != tcc_pkg::CNT_MAX) ? tjump_cnt_r + 16'd1
                                                                    : tjump_cnt_r;

  always_comb begin
    res.slot_jump           = f_jump;
    res.slot_cycle_mismatch = f_mis;
    res.gps_jump            = f_time;
    res.bad_interval        = f_ivl;
    res.count_changed       = f_cnt;
    res.any_error           = f_jump | f_mis | f_time;
    res.slot_jump_total     = jump_cnt_nxt;
    res.mismatch_total      = mis_cnt_nxt;
    res.gps_jump_total      = tjump_cnt_nxt;
  end

  assign out_valid_nxt = s1_take ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      jump_cnt_r  <= 16'd0;
      mis_cnt_r   <= 16'd0;
      tjump_cnt_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        primed_r    <= 1'b1;
        jump_cnt_r  <= jump_cnt_nxt;
        mis_cnt_r   <= mis_cnt_nxt;
        tjump_cnt_r <= tjump_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      last_slot_r     <= s1_data.ring_slot;
      last_seconds_r  <= s1_data.gps_seconds;
      last_subcycle_r <= s1_data.gps_subcycle;
      last_models_r   <= s1_data.model_count;
      out_data_r      <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_any_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.any_error == (out_data_r.slot_jump |
                     out_data_r.slot_cycle_mismatch | out_data_r.gps_jump)))
    else $error("any_error disagrees with flags");

  a_prime_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && !primed_r) |=> (!out_data_r.slot_jump && !out_data_r.gps_jump &&
                                !out_data_r.bad_interval && !out_data_r.count_changed))
    else $error("priming sample raised a continuity flag");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((jump_cnt_r == $past(jump_cnt_r)) ||
                      (jump_cnt_r == $past(jump_cnt_r) + 16'd1)))
    else $error("slot jump counter moved by more than one");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_take |=> ($stable(mis_cnt_r) && $stable(tjump_cnt_r)))
    else $error("counter changed without a sample");

  a_total_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=> (out_data_r.gps_jump_total == tjump_cnt_r))
    else $error("reported total differs from counter");

endmodule

### sv/timestamp_continuity_checker.sv
// ----------------------------------------------------------------------------
// timestamp_continuity_checker: acquisition sample continuity monitor
// Flags ring slot jumps, slot/cycle mismatches, GPS time jumps, interval
// window violations and model count changes, with saturating totals.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload            direction
//   --------  ------------------  -----------------  ---------
//   in_       in_valid/in_stall   tcc_pkg::in_t      sample in
//   out_      out_valid/out_stall tcc_pkg::out_t     result out
//   cfg_      cfg_valid/cfg_ready index + 16b data   register write
//
// One beat per cycle sustained while out_stall is low; a result is valid on out_
// once its sample passes the input register and check logic into the result register.
// Synchronous active-low reset restores the ring/window defaults, empties both
// stages, zeroes the totals and un-primes the checker; cfg_ready is always high.
// While out_stall holds, the result stays put and the input register takes one
// more beat; in_stall then stays high until out_stall drops.
module timestamp_continuity_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcc_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  tcc_pkg::cfg_t cfg;
  logic          s1_valid;
  tcc_pkg::in_t  s1_data;
  logic          s1_take;

  // register file: ring size and interval window
  tcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // capture incoming sample beat
  tcc_input_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (s1_take)
  );

  // compare against stored sample, advance totals, register result; the
  // first sample after reset only primes the stored sample (mismatch still
  // counted)
  tcc_check u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
